// ===== hdl/ppf_pkg.sv =====
package ppf_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = WORD_WIDTH - 1;

    localparam logic [CFG_WIDTH-1:0] ONE_FIXED = CFG_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [1:0]
    {
        CFG_MASS        = 2'd0,
        CFG_CORE_RADIUS = 2'd1,
        CFG_PLANAR_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_SATURATED = 2'd1,
        STATUS_SINGULAR  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic signed [WORD_WIDTH-1:0] pos_x;
        logic signed [WORD_WIDTH-1:0] pos_y;
        logic signed [WORD_WIDTH-1:0] pos_z;
    } pos_t;

    typedef struct packed
    {
        logic signed [WORD_WIDTH-1:0] potential;
        logic signed [WORD_WIDTH-1:0] acc_x;
        logic signed [WORD_WIDTH-1:0] acc_y;
        logic signed [WORD_WIDTH-1:0] acc_z;
        status_t                      status;
    } result_t;

endpackage

// ===== hdl/ppf_sqrt_pipe.sv =====
module ppf_sqrt_pipe #(
    parameter int ROOT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [2*ROOT_WIDTH-1:0] radicand,
    output logic [ROOT_WIDTH-1:0]   root
);

    localparam int REM_WIDTH = ROOT_WIDTH + 3;
    localparam int RAD_WIDTH = 2 * ROOT_WIDTH;

    logic [ROOT_WIDTH-1:0] root_reg  [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] root_next [ROOT_WIDTH];
    logic [REM_WIDTH-1:0]  rem_reg   [ROOT_WIDTH-1];
    logic [REM_WIDTH-1:0]  rem_next  [ROOT_WIDTH-1];
    logic [RAD_WIDTH-1:0]  rad_reg   [ROOT_WIDTH-1];
    logic [RAD_WIDTH-1:0]  rad_next  [ROOT_WIDTH-1];

    always_comb
    begin
        logic [ROOT_WIDTH-1:0] prev_root;
        logic [REM_WIDTH-1:0]  prev_rem;
        logic [RAD_WIDTH-1:0]  prev_rad;
        logic [REM_WIDTH-1:0]  rem_sh;
        logic [REM_WIDTH-1:0]  trial;
        logic                  take;
        for (int j = 0; j < ROOT_WIDTH; j++)
        begin
            if (j == 0)
            begin
                prev_root = '0;
                prev_rem  = '0;
                prev_rad  = radicand;
            end
            else
            begin
                prev_root = root_reg[j-1];
                prev_rem  = rem_reg[j-1];
                prev_rad  = rad_reg[j-1];
            end
            rem_sh = {prev_rem[REM_WIDTH-3:0], prev_rad[RAD_WIDTH-1:RAD_WIDTH-2]};
            trial  = {1'b0, prev_root, 2'b01};
            take   = rem_sh >= trial;
            root_next[j] = {prev_root[ROOT_WIDTH-2:0], take};
            if (j < ROOT_WIDTH - 1)
            begin
                rem_next[j] = take ? (rem_sh - trial) : rem_sh;
                rad_next[j] = {prev_rad[RAD_WIDTH-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < ROOT_WIDTH; j++)
            begin
                root_reg[j] <= root_next[j];
            end
            for (int j = 0; j < ROOT_WIDTH - 1; j++)
            begin
                rem_reg[j] <= rem_next[j];
                rad_reg[j] <= rad_next[j];
            end
        end
    end

    assign root = root_reg[ROOT_WIDTH-1];

endmodule

// ===== hdl/ppf_div_pipe.sv =====
module ppf_div_pipe #(
    parameter int NUM_WIDTH = 47,
    parameter int DEN_WIDTH = 32,
    parameter int QUO_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic [QUO_WIDTH-1:0] quo,
    output logic                 ovf
);

    localparam int HI_WIDTH  = NUM_WIDTH - QUO_WIDTH;
    localparam int CMP_WIDTH = (HI_WIDTH > DEN_WIDTH) ? HI_WIDTH : DEN_WIDTH;

    logic [CMP_WIDTH-1:0] hi_ext;
    logic [CMP_WIDTH-1:0] den_ext;

    logic [DEN_WIDTH-1:0] rem_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] rem_next [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_next [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] low_reg  [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] low_next [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] quo_reg  [QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0] quo_next [QUO_WIDTH+1];
    logic                 ovf_reg  [QUO_WIDTH+1];
    logic                 ovf_next [QUO_WIDTH+1];

    assign hi_ext  = CMP_WIDTH'(num[NUM_WIDTH-1:QUO_WIDTH]);
    assign den_ext = CMP_WIDTH'(den);

    always_comb
    begin
        logic [DEN_WIDTH:0] rem_sh;
        logic [DEN_WIDTH:0] diff;
        logic               take;
        rem_next[0] = hi_ext[DEN_WIDTH-1:0];
        den_next[0] = den;
        low_next[0] = num[QUO_WIDTH-1:0];
        quo_next[0] = '0;
        ovf_next[0] = hi_ext >= den_ext;
        for (int j = 1; j <= QUO_WIDTH; j++)
        begin
            rem_sh = {rem_reg[j-1], low_reg[j-1][QUO_WIDTH-1]};
            diff   = rem_sh - {1'b0, den_reg[j-1]};
            take   = rem_sh >= {1'b0, den_reg[j-1]};
            quo_next[j] = {quo_reg[j-1][QUO_WIDTH-2:0], take};
            ovf_next[j] = ovf_reg[j-1];
            if (j < QUO_WIDTH)
            begin
                rem_next[j] = take ? diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
                den_next[j] = den_reg[j-1];
                low_next[j] = {low_reg[j-1][QUO_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QUO_WIDTH; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_next[j];
                low_reg[j] <= low_next[j];
            end
            for (int j = 0; j <= QUO_WIDTH; j++)
            begin
                quo_reg[j] <= quo_next[j];
                ovf_reg[j] <= ovf_next[j];
            end
        end
    end

    assign quo = quo_reg[QUO_WIDTH];
    assign ovf = ovf_reg[QUO_WIDTH];

endmodule

// ===== hdl/plummer_potential_force_top.sv =====
// Plummer potential and acceleration for a stream of Q16.16 positions. One position may be
// taken in every cycle and each gives exactly one result, 2 * WORD_WIDTH + 7 cycles later
// (71 cycles at 32 bits): the depth is set by the bit-per-stage square root and the
// bit-per-stage dividers, which run the four quotients side by side. When the output
// transaction is stalled the whole pipeline holds, so in_stall follows out_stall while a
// result waits. Mass, core radius and planar mode are written through the configuration
// port, which is always ready, and should only change while no transaction is in flight.
module plummer_potential_force_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  ppf_pkg::cfg_index_t                cfg_index,
    input  logic [ppf_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ppf_pkg::pos_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ppf_pkg::result_t                   out_data
);

    localparam int W       = ppf_pkg::WORD_WIDTH;
    localparam int F       = ppf_pkg::FRAC_BITS;
    localparam int CW      = ppf_pkg::CFG_WIDTH;
    localparam int SW      = 2 * W;
    localparam int DW      = 3 * W;
    localparam int MKW     = CW + W;
    localparam int POT_NW  = CW + F;
    localparam int ACC_NW  = MKW + 2 * F;

    typedef struct packed
    {
        logic [CW-1:0] mass;
        logic [W-1:0]  mag_x;
        logic [W-1:0]  mag_y;
        logic [W-1:0]  mag_z;
        logic          neg_x;
        logic          neg_y;
        logic          neg_z;
        logic          singular;
        logic [SW-1:0] s;
    } root_side_t;

    typedef struct packed
    {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic singular;
    } div_side_t;

    function automatic logic [W:0] clip(input logic [W-1:0] q, input logic of,
                                        input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] m;
        logic         sat;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sat = of || (q > lim);
        m   = sat ? lim : q;
        return {sat, neg ? (~m + W'(1)) : m};
    endfunction

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    logic en;

    logic [CW-1:0] mass_reg;
    logic [CW-1:0] core_radius_reg;
    logic          planar_mode_reg;

    logic          a_valid_reg;
    logic [CW-1:0] a_mass_reg;
    logic [CW-1:0] a_rc_reg;
    logic [W-1:0]  a_mag_x_reg, a_mag_y_reg, a_mag_z_reg;
    logic          a_neg_x_reg, a_neg_y_reg, a_neg_z_reg;

    logic            b_valid_reg;
    logic [CW-1:0]   b_mass_reg;
    logic [2*CW-1:0] b_rc_sq_next;
    logic [SW-1:0]   b_rc_sq_reg, b_x_sq_reg, b_y_sq_reg, b_z_sq_reg;
    logic [W-1:0]    b_mag_x_reg, b_mag_y_reg, b_mag_z_reg;
    logic            b_neg_x_reg, b_neg_y_reg, b_neg_z_reg;

    logic          c_valid_reg;
    root_side_t    c_side_next;
    root_side_t    c_side_reg;

    root_side_t    rs_reg [W];
    logic [W-1:0]  rs_valid_reg;
    root_side_t    rs_tail;
    logic [W-1:0]  root;

    logic           e_valid_reg;
    logic [SW-1:0]  e_sr_lo_reg, e_sr_hi_reg;
    logic [MKW-1:0] e_mk_x_reg, e_mk_y_reg, e_mk_z_reg;
    logic [W-1:0]   e_root_reg;
    logic [CW-1:0]  e_mass_reg;
    div_side_t      e_side_reg;

    logic           f_valid_reg;
    logic [DW-1:0]  f_den_reg;
    logic [MKW-1:0] f_mk_x_reg, f_mk_y_reg, f_mk_z_reg;
    logic [W-1:0]   f_root_reg;
    logic [CW-1:0]  f_mass_reg;
    div_side_t      f_side_reg;

    div_side_t      ds_reg [W+1];
    logic [W:0]     ds_valid_reg;
    div_side_t      ds_tail;

    logic [W-1:0]   pot_q, ax_q, ay_q, az_q;
    logic           pot_ovf, ax_ovf, ay_ovf, az_ovf;

    logic             out_valid_reg;
    ppf_pkg::result_t out_data_reg;
    ppf_pkg::result_t out_data_next;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg        <= ppf_pkg::ONE_FIXED;
            core_radius_reg <= ppf_pkg::ONE_FIXED;
            planar_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppf_pkg::CFG_MASS:        mass_reg        <= cfg_data;
                ppf_pkg::CFG_CORE_RADIUS: core_radius_reg <= cfg_data;
                ppf_pkg::CFG_PLANAR_MODE: planar_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            rs_valid_reg  <= '0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            ds_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            rs_valid_reg  <= {rs_valid_reg[W-2:0], c_valid_reg};
            e_valid_reg   <= rs_valid_reg[W-1];
            f_valid_reg   <= e_valid_reg;
            ds_valid_reg  <= {ds_valid_reg[W-1:0], f_valid_reg};
            out_valid_reg <= ds_valid_reg[W];
        end
    end

    // In planar mode z is dropped at the front, so its acceleration comes out as zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mass_reg  <= mass_reg;
            a_rc_reg    <= core_radius_reg;
            a_mag_x_reg <= magnitude(in_data.pos_x);
            a_mag_y_reg <= magnitude(in_data.pos_y);
            a_mag_z_reg <= planar_mode_reg ? '0 : magnitude(in_data.pos_z);
            a_neg_x_reg <= in_data.pos_x[W-1];
            a_neg_y_reg <= in_data.pos_y[W-1];
            a_neg_z_reg <= in_data.pos_z[W-1] && !planar_mode_reg;
        end
    end

    assign b_rc_sq_next = a_rc_reg * a_rc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mass_reg  <= a_mass_reg;
            b_rc_sq_reg <= SW'(b_rc_sq_next);
            b_x_sq_reg  <= a_mag_x_reg * a_mag_x_reg;
            b_y_sq_reg  <= a_mag_y_reg * a_mag_y_reg;
            b_z_sq_reg  <= a_mag_z_reg * a_mag_z_reg;
            b_mag_x_reg <= a_mag_x_reg;
            b_mag_y_reg <= a_mag_y_reg;
            b_mag_z_reg <= a_mag_z_reg;
            b_neg_x_reg <= a_neg_x_reg;
            b_neg_y_reg <= a_neg_y_reg;
            b_neg_z_reg <= a_neg_z_reg;
        end
    end

    always_comb
    begin
        c_side_next.mass     = b_mass_reg;
        c_side_next.mag_x    = b_mag_x_reg;
        c_side_next.mag_y    = b_mag_y_reg;
        c_side_next.mag_z    = b_mag_z_reg;
        c_side_next.neg_x    = b_neg_x_reg;
        c_side_next.neg_y    = b_neg_y_reg;
        c_side_next.neg_z    = b_neg_z_reg;
        c_side_next.s        = b_rc_sq_reg + b_x_sq_reg + b_y_sq_reg + b_z_sq_reg;
        c_side_next.singular = (c_side_next.s == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= c_side_next;
            rs_reg[0]  <= c_side_reg;
            for (int i = 1; i < W; i++)
            begin
                rs_reg[i] <= rs_reg[i-1];
            end
        end
    end

    ppf_sqrt_pipe #(
        .ROOT_WIDTH (W)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (c_side_reg.s),
        .root     (root)
    );

    assign rs_tail = rs_reg[W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sr_lo_reg         <= rs_tail.s[W-1:0] * root;
            e_sr_hi_reg         <= rs_tail.s[SW-1:W] * root;
            e_mk_x_reg          <= rs_tail.mass * rs_tail.mag_x;
            e_mk_y_reg          <= rs_tail.mass * rs_tail.mag_y;
            e_mk_z_reg          <= rs_tail.mass * rs_tail.mag_z;
            e_root_reg          <= root;
            e_mass_reg          <= rs_tail.mass;
            e_side_reg.neg_x    <= rs_tail.neg_x;
            e_side_reg.neg_y    <= rs_tail.neg_y;
            e_side_reg.neg_z    <= rs_tail.neg_z;
            e_side_reg.singular <= rs_tail.singular;

            f_den_reg  <= {e_sr_hi_reg, {W{1'b0}}} + DW'(e_sr_lo_reg);
            f_mk_x_reg <= e_mk_x_reg;
            f_mk_y_reg <= e_mk_y_reg;
            f_mk_z_reg <= e_mk_z_reg;
            f_root_reg <= e_root_reg;
            f_mass_reg <= e_mass_reg;
            f_side_reg <= e_side_reg;

            ds_reg[0] <= f_side_reg;
            for (int i = 1; i <= W; i++)
            begin
                ds_reg[i] <= ds_reg[i-1];
            end
        end
    end

    ppf_div_pipe #(
        .NUM_WIDTH (POT_NW),
        .DEN_WIDTH (W),
        .QUO_WIDTH (W)
    ) u_div_pot (
        .clk (clk),
        .en  (en),
        .num ({f_mass_reg, {F{1'b0}}}),
        .den (f_root_reg),
        .quo (pot_q),
        .ovf (pot_ovf)
    );

    ppf_div_pipe #(
        .NUM_WIDTH (ACC_NW),
        .DEN_WIDTH (DW),
        .QUO_WIDTH (W)
    ) u_div_x (
        .clk (clk),
        .en  (en),
        .num ({f_mk_x_reg, {(2*F){1'b0}}}),
        .den (f_den_reg),
        .quo (ax_q),
        .ovf (ax_ovf)
    );

    ppf_div_pipe #(
        .NUM_WIDTH (ACC_NW),
        .DEN_WIDTH (DW),
        .QUO_WIDTH (W)
    ) u_div_y (
        .clk (clk),
        .en  (en),
        .num ({f_mk_y_reg, {(2*F){1'b0}}}),
        .den (f_den_reg),
        .quo (ay_q),
        .ovf (ay_ovf)
    );

    ppf_div_pipe #(
        .NUM_WIDTH (ACC_NW),
        .DEN_WIDTH (DW),
        .QUO_WIDTH (W)
    ) u_div_z (
        .clk (clk),
        .en  (en),
        .num ({f_mk_z_reg, {(2*F){1'b0}}}),
        .den (f_den_reg),
        .quo (az_q),
        .ovf (az_ovf)
    );

    assign ds_tail = ds_reg[W];

    always_comb
    begin
        logic [W:0] pot_w;
        logic [W:0] ax_w;
        logic [W:0] ay_w;
        logic [W:0] az_w;
        pot_w = clip(pot_q, pot_ovf, 1'b1);
        ax_w  = clip(ax_q, ax_ovf, !ds_tail.neg_x);
        ay_w  = clip(ay_q, ay_ovf, !ds_tail.neg_y);
        az_w  = clip(az_q, az_ovf, !ds_tail.neg_z);
        if (ds_tail.singular)
        begin
            out_data_next.potential = '0;
            out_data_next.acc_x     = '0;
            out_data_next.acc_y     = '0;
            out_data_next.acc_z     = '0;
            out_data_next.status    = ppf_pkg::STATUS_SINGULAR;
        end
        else
        begin
            out_data_next.potential = $signed(pot_w[W-1:0]);
            out_data_next.acc_x     = $signed(ax_w[W-1:0]);
            out_data_next.acc_y     = $signed(ay_w[W-1:0]);
            out_data_next.acc_z     = $signed(az_w[W-1:0]);
            if (pot_w[W] || ax_w[W] || ay_w[W] || az_w[W])
            begin
                out_data_next.status = ppf_pkg::STATUS_SATURATED;
            end
            else
            begin
                out_data_next.status = ppf_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == ppf_pkg::STATUS_SINGULAR) |->
        (out_data_reg.potential == '0 && out_data_reg.acc_x == '0 &&
         out_data_reg.acc_y == '0 && out_data_reg.acc_z == '0))
        else $error("Singular transaction carries a non-zero result.");

    a_potential_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.potential > 0))
        else $error("Potential came out positive.");

    a_saturated_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == ppf_pkg::STATUS_SATURATED) |->
        (out_data_reg.potential == {1'b1, {(W-1){1'b0}}} ||
         out_data_reg.acc_x == {1'b1, {(W-1){1'b0}}} ||
         out_data_reg.acc_x == {1'b0, {(W-1){1'b1}}} ||
         out_data_reg.acc_y == {1'b1, {(W-1){1'b0}}} ||
         out_data_reg.acc_y == {1'b0, {(W-1){1'b1}}} ||
         out_data_reg.acc_z == {1'b1, {(W-1){1'b0}}} ||
         out_data_reg.acc_z == {1'b0, {(W-1){1'b1}}}))
        else $error("Saturated status without a clipped field.");

endmodule
